FILE: hw/rtl/nnto_pkg.sv
// nnto_pkg: shared types and constants for the nearest-neighbor tour order block
// used by nnto_cell and nearest_neighbor_tour_order; no dependencies
`default_nettype none

package nnto_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned SQ_W    = 2 * COORD_W;
  localparam int unsigned DIST_W  = SQ_W + 1;
  localparam int unsigned VIDX_W  = 4;

  // input word: one point of the list
  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } point_in_t;

  // output word: one tour entry
  typedef struct packed {
    logic [VIDX_W-1:0] visit_index;
    logic              last_visit;
  } visit_out_t;

  // running minimum handed from cell to cell
  typedef struct packed {
    logic                      have;
    logic [DIST_W-1:0]         dsq;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } nnto_tok_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nnto_cell.sv
// nnto_cell: one point slot of the search chain; holds a point, its visit state
// and its distance to the current point, and passes on the running minimum
// depends on nnto_pkg
`default_nettype none

module nnto_cell
  import nnto_pkg::*;
#(
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      clr_i,
  input  wire logic                      wr_en_i,
  input  wire logic [IDX_W-1:0]          wr_idx_i,
  input  wire logic signed [COORD_W-1:0] wr_x_i,
  input  wire logic signed [COORD_W-1:0] wr_y_i,
  input  wire logic                      mark_en_i,
  input  wire logic [IDX_W-1:0]          mark_idx_i,
  input  wire logic signed [COORD_W-1:0] cur_x_i,
  input  wire logic signed [COORD_W-1:0] cur_y_i,
  input  wire nnto_tok_t                 tok_i,
  input  wire logic [IDX_W-1:0]          idx_i,
  output nnto_tok_t                      tok_o,
  output logic [IDX_W-1:0]               idx_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic signed [COORD_W-1:0] x_q, y_q;
  logic                      loaded_q, visited_q;
  logic [COORD_W-1:0]        dx_q, dy_q;
  logic [SQ_W-1:0]           dx2_q, dy2_q;
  logic [DIST_W-1:0]         dist_q;
  logic signed [COORD_W:0]   diff_x, diff_y;
  logic [COORD_W:0]          abs_x, abs_y;
  logic                      take_own;
  nnto_tok_t                 tok_d, tok_q;
  logic [IDX_W-1:0]          idx_d, idx_q;

  // point storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_idx_i == MyIdx) begin
      x_q <= wr_x_i;
      y_q <= wr_y_i;
    end
  end

  // slot state: loaded and visited; a mark wins over a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q  <= 1'b0;
      visited_q <= 1'b0;
    end else if (clr_i) begin
      loaded_q  <= 1'b0;
      visited_q <= 1'b0;
    end else begin
      if (wr_en_i && wr_idx_i == MyIdx) begin
        loaded_q <= 1'b1;
      end
      if (mark_en_i && mark_idx_i == MyIdx) begin
        visited_q <= 1'b1;
      end else if (wr_en_i && wr_idx_i == MyIdx) begin
        visited_q <= 1'b0;
      end
    end
  end

  // absolute coordinate differences
  always_comb begin
    diff_x = {cur_x_i[COORD_W-1], cur_x_i} - {x_q[COORD_W-1], x_q};
    diff_y = {cur_y_i[COORD_W-1], cur_y_i} - {y_q[COORD_W-1], y_q};
    abs_x  = diff_x[COORD_W] ? (COORD_W+1)'(-diff_x) : diff_x;
    abs_y  = diff_y[COORD_W] ? (COORD_W+1)'(-diff_y) : diff_y;
  end

  // squared distance, three register stages
  always_ff @(posedge clk_i) begin
    dx_q   <= abs_x[COORD_W-1:0];
    dy_q   <= abs_y[COORD_W-1:0];
    dx2_q  <= dx_q * dx_q;
    dy2_q  <= dy_q * dy_q;
    dist_q <= {1'b0, dx2_q} + {1'b0, dy2_q};
  end

  // running minimum; on a tie the lower index upstream keeps it
  always_comb begin
    take_own = loaded_q && !visited_q && (!tok_i.have || dist_q < tok_i.dsq);
    if (take_own) begin
      tok_d.have = 1'b1;
      tok_d.dsq  = dist_q;
      tok_d.x    = x_q;
      tok_d.y    = y_q;
      idx_d      = MyIdx;
    end else begin
      tok_d = tok_i;
      idx_d = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      idx_q <= '0;
    end else begin
      tok_q <= tok_d;
      idx_q <= idx_d;
    end
  end

  assign tok_o = tok_q;
  assign idx_o = idx_q;

endmodule

`default_nettype wire

FILE: hw/rtl/nearest_neighbor_tour_order.sv
// Nearest-neighbor tour order: collects 2-D points and emits a greedy tour.
//
// Input channel (in_valid_i / in_stall_o / in_word_i): one point per word, the
// first being the start. Words are taken one per cycle while loading; points
// past MAX_POINTS are dropped. A word with last_point set starts the search and
// in_stall_o stays high until the tour has been handed to the output register.
// Output channel (out_valid_o / out_stall_i / out_word_o): one word per tour
// entry in visit order, then index 0 with last_visit set.
// The current point is broadcast to a row of MAX_POINTS cells, each cell
// registers its squared distance through dx_q, dx2_q and dist_q, and the
// running minimum walks the row one cell per cycle. A stalled output word
// holds and the search waits for the output register to drain. The final
// word still waiting does not block loading of the next list.
// Reset clears the list, the visit state and the output register.
// depends on nnto_pkg and nnto_cell
`default_nettype none

module nearest_neighbor_tour_order
  import nnto_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire point_in_t  in_word_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output visit_out_t      out_word_o
);

  localparam int unsigned IDX_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int unsigned WAIT_CYC = MAX_POINTS + 4;
  localparam int unsigned WAIT_W   = $clog2(WAIT_CYC + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_FINAL
  } state_e;

  state_e                    state_q;
  logic [CNT_W-1:0]          count_q;
  logic [IDX_W-1:0]          steps_q;
  logic [WAIT_W-1:0]         wait_q;
  logic signed [COORD_W-1:0] cur_x_q, cur_y_q;
  logic                      out_valid_q;
  visit_out_t                out_word_q;

  logic                      in_acc, out_free, has_room, wr_en, clr;
  logic                      mark_en, search_done, out_load;
  logic [IDX_W-1:0]          mark_idx;
  logic [CNT_W-1:0]          n_pts;

  nnto_tok_t                 tok   [MAX_POINTS+1];
  logic [IDX_W-1:0]          idx_c [MAX_POINTS+1];

  // handshake
  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign has_room    = (count_q != CNT_W'(MAX_POINTS));
  assign wr_en       = in_acc && has_room;
  assign n_pts       = has_room ? count_q + CNT_W'(1) : count_q;
  assign search_done = (wait_q == WAIT_W'(WAIT_CYC));
  assign out_load    = ((state_q == ST_SEARCH) && search_done && out_free) ||
                       ((state_q == ST_FINAL) && out_free);

  // visit marking: start point at list end, chosen point on each step; the list is cleared as the final word loads
  always_comb begin
    mark_en  = 1'b0;
    mark_idx = '0;
    clr      = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        mark_en = in_acc && in_word_i.last_point;
      end
      ST_SEARCH: begin
        mark_en  = search_done && out_free;
        mark_idx = idx_c[MAX_POINTS];
      end
      ST_FINAL: begin
        clr = out_free;
      end
      default: begin
        clr = 1'b0;
      end
    endcase
  end

  // the row of cells
  assign tok[0]   = '0;
  assign idx_c[0] = '0;

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    nnto_cell #(
      .IDX_W   (IDX_W),
      .CELL_IDX(k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clr_i     (clr),
      .wr_en_i   (wr_en),
      .wr_idx_i  (count_q[IDX_W-1:0]),
      .wr_x_i    (in_word_i.point_x),
      .wr_y_i    (in_word_i.point_y),
      .mark_en_i (mark_en),
      .mark_idx_i(mark_idx),
      .cur_x_i   (cur_x_q),
      .cur_y_i   (cur_y_q),
      .tok_i     (tok[k]),
      .idx_i     (idx_c[k]),
      .tok_o     (tok[k+1]),
      .idx_o     (idx_c[k+1])
    );
  end

  // current point coordinates
  always_ff @(posedge clk_i) begin
    if (wr_en && count_q == '0) begin
      cur_x_q <= in_word_i.point_x;
      cur_y_q <= in_word_i.point_y;
    end else if (state_q == ST_SEARCH && search_done && out_free) begin
      cur_x_q <= tok[MAX_POINTS].x;
      cur_y_q <= tok[MAX_POINTS].y;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      steps_q     <= '0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (wr_en) begin
            count_q <= count_q + CNT_W'(1);
          end
          if (in_acc && in_word_i.last_point) begin
            steps_q <= IDX_W'(n_pts - CNT_W'(1));
            wait_q  <= '0;
            state_q <= (n_pts == CNT_W'(1)) ? ST_FINAL : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (!search_done) begin
            wait_q <= wait_q + WAIT_W'(1);
          end else if (out_free) begin
            out_word_q.visit_index <= VIDX_W'(idx_c[MAX_POINTS]);
            out_word_q.last_visit  <= 1'b0;
            wait_q                 <= '0;
            steps_q                <= steps_q - IDX_W'(1);
            if (steps_q == IDX_W'(1)) begin
              state_q <= ST_FINAL;
            end
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            out_word_q.visit_index <= '0;
            out_word_q.last_visit  <= 1'b1;
            count_q                <= '0;
            state_q                <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking bench for nearest_neighbor_tour_order, point lists in, tour entries out
// directed lists check a typed tour or, like random lists, a built-in greedy tour predictor
// depends on nnto_pkg and the nearest_neighbor_tour_order rtl
`timescale 1ns / 1ps

module tb;
  import nnto_pkg::*;

  localparam int PTS          = 16;
  localparam int RAND_ITEMS   = 250;
  localparam int HOLD_AFTER   = 60;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 400;
  localparam int LIMIT_CYCLES = 400000;

  typedef enum int {GAP_NONE, GAP_SPARSE, GAP_FULL} gap_mode_e;
  typedef enum int {CRD_FULL, CRD_TIGHT, CRD_EDGE} coord_kind_e;

  // one row of the directed table; typed tour has the first visit in the low nibble
  typedef struct packed {
    point_in_t   word;
    logic [4:0]  tour_len;
    logic [15:0] tour;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  point_in_t  in_word_i;
  logic       out_valid_o;
  logic       out_stall_i;
  visit_out_t out_word_o;

  nearest_neighbor_tour_order #(
    .MAX_POINTS(PTS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // predictor copy of the point list
  logic signed [COORD_W-1:0] pt_x [PTS];
  logic signed [COORD_W-1:0] pt_y [PTS];
  int                        n_loaded;

  visit_out_t tour_expect_q[$];
  stim_row_t  dir_rows[$];

  // typed tour handed from the sender to the monitor with the current word
  int          typed_len;
  logic [15:0] typed_tour;

  gap_mode_e send_mode;
  gap_mode_e recv_mode;
  int        err_cnt;
  int        points_taken;
  int        lists_done;
  int        visits_seen;
  bit        hold_done;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("%0t timeout after %0d cycles, %0d tour entries pending", $time, LIMIT_CYCLES,
             tour_expect_q.size());
    $display("nearest_neighbor_tour_order verification failed");
    $finish;
  end

  function automatic int pick_gap(gap_mode_e mode);
    case (mode)
      GAP_NONE:   return 0;
      GAP_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      default:    return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord(coord_kind_e kind);
    case (kind)
      CRD_TIGHT: return COORD_W'($urandom_range(0, 6) - 3);
      CRD_EDGE: begin
        case ($urandom_range(0, 5))
          0:       return 16'h8000;
          1:       return 16'h8001;
          2:       return 16'hffff;
          3:       return 16'h0000;
          4:       return 16'h7ffe;
          default: return 16'h7fff;
        endcase
      end
      default:   return COORD_W'($urandom);
    endcase
  endfunction

  function automatic stim_row_t mk_row(int x, int y, bit last, int len, logic [15:0] tour);
    stim_row_t r;
    r.word.point_x    = x[COORD_W-1:0];
    r.word.point_y    = y[COORD_W-1:0];
    r.word.last_point = last;
    r.tour_len        = 5'(len);
    r.tour            = tour;
    return r;
  endfunction

  // append one row to the directed table
  task automatic add_row(input int x, input int y, input bit last, input int len,
                         input logic [15:0] tour);
    dir_rows.insert(dir_rows.size(), mk_row(x, y, last, len, tour));
  endtask

  // append one expected tour entry
  task automatic expect_visit(input visit_out_t v);
    tour_expect_q.insert(tour_expect_q.size(), v);
  endtask

  // exact squared distance between two stored points
  function automatic longint unsigned dist_sq(int a, int b);
    longint dx;
    longint dy;
    dx = longint'(pt_x[a]) - longint'(pt_x[b]);
    dy = longint'(pt_y[a]) - longint'(pt_y[b]);
    return longint'(dx * dx + dy * dy);
  endfunction

  // greedy tour over the stored list, lower index wins ties, then return to start
  task automatic predict_tour();
    logic [PTS-1:0]  seen;
    int              cur;
    int              best_idx;
    longint unsigned best;
    longint unsigned d;
    bit              have;
    visit_out_t      v;
    seen    = '0;
    seen[0] = 1'b1;
    cur     = 0;
    for (int s = 1; s < n_loaded; s++) begin
      have     = 1'b0;
      best     = 0;
      best_idx = 0;
      for (int j = 0; j < n_loaded; j++) begin
        if (!seen[j]) begin
          d = dist_sq(cur, j);
          if (!have || d < best) begin
            have     = 1'b1;
            best     = d;
            best_idx = j;
          end
        end
      end
      seen[best_idx] = 1'b1;
      cur            = best_idx;
      v.visit_index  = VIDX_W'(best_idx);
      v.last_visit   = 1'b0;
      expect_visit(v);
    end
    v.visit_index = '0;
    v.last_visit  = 1'b1;
    expect_visit(v);
  endtask

  // store an accepted point, and on the last one queue the tour
  task automatic accept_point(input point_in_t w);
    visit_out_t v;
    points_taken++;
    if (n_loaded < PTS) begin
      pt_x[n_loaded] = w.point_x;
      pt_y[n_loaded] = w.point_y;
      n_loaded++;
    end
    if (w.last_point) begin
      if (typed_len == 0) begin
        predict_tour();
      end else begin
        for (int k = 0; k < typed_len; k++) begin
          v.visit_index = typed_tour[4*k +: 4];
          v.last_visit  = (k == typed_len - 1);
          expect_visit(v);
        end
      end
      n_loaded = 0;
      lists_done++;
    end
  endtask

  task automatic check_visit(input visit_out_t got);
    visit_out_t want;
    visits_seen++;
    if (tour_expect_q.size() == 0) begin
      $display("%0t tour entry index %0d last %0b with nothing expected", $time,
               got.visit_index, got.last_visit);
      err_cnt++;
    end else begin
      want = tour_expect_q.pop_front();
      if (got.visit_index !== want.visit_index) begin
        $display("%0t visit_index mismatch: expected %0d, got %0d", $time,
                 want.visit_index, got.visit_index);
        err_cnt++;
      end
      if (got.last_visit !== want.last_visit) begin
        $display("%0t last_visit mismatch: expected %0b, got %0b", $time,
                 want.last_visit, got.last_visit);
        err_cnt++;
      end
    end
  endtask

  // monitor both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) accept_point(in_word_i);
      if (out_valid_o && !out_stall_i) check_visit(out_word_o);
    end
  end

  // offer one word after a drawn gap and wait until it is taken
  task automatic send_point(input point_in_t w, input int len, input logic [15:0] tour);
    int gap;
    gap = pick_gap(send_mode);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    typed_len  = len;
    typed_tour = tour;
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // receiver: drawn stall before each word, one long hold-off to back the block up
  initial begin : recv_proc
    int gap;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && visits_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        gap       = HOLD_CYCLES;
      end else begin
        gap = pick_gap(recv_mode);
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // stimulus
  initial begin : send_proc
    point_in_t   w;
    int          len;
    int          rand_items;
    coord_kind_e kind;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    n_loaded     = 0;
    typed_len    = 0;
    typed_tour   = '0;
    err_cnt      = 0;
    points_taken = 0;
    lists_done   = 0;
    visits_seen  = 0;
    hold_done    = 1'b0;
    rand_items   = 0;
    send_mode    = GAP_FULL;
    recv_mode    = GAP_FULL;

    // single point at the coordinate extremes
    add_row(-32768, 32767, 1'b1, 1, 16'h0000);
    // two coincident points
    add_row(5, 5, 1'b0, 0, 16'h0000);
    add_row(5, 5, 1'b1, 2, 16'h0001);
    // corners: widest possible distances
    add_row(-32768, -32768, 1'b0, 0, 16'h0000);
    add_row(32767, 32767, 1'b0, 0, 16'h0000);
    add_row(-32768, 32767, 1'b1, 3, 16'h0012);
    // equal distances, lower index wins
    add_row(0, 0, 1'b0, 0, 16'h0000);
    add_row(1, 0, 1'b0, 0, 16'h0000);
    add_row(-1, 0, 1'b0, 0, 16'h0000);
    add_row(0, 5, 1'b1, 4, 16'h0321);
    // full list plus a dropped point that carries the last flag
    for (int i = 0; i <= PTS; i++) begin
      add_row((i * 7919) % 65536 - 32768, (i * 40503) % 65536 - 32768,
              i == PTS, 0, 16'h0000);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_point(dir_rows[i].word, dir_rows[i].tour_len, dir_rows[i].tour);

    // random lists, mostly within capacity, a few past it
    while (rand_items < RAND_ITEMS) begin
      len       = ($urandom_range(0, 9) == 0) ? $urandom_range(PTS + 1, PTS + 4)
                                              : $urandom_range(1, PTS);
      kind      = coord_kind_e'($urandom_range(0, 2));
      send_mode = gap_mode_e'($urandom_range(0, 2));
      recv_mode = gap_mode_e'($urandom_range(0, 2));
      for (int k = 0; k < len; k++) begin
        w.point_x    = rand_coord(kind);
        w.point_y    = rand_coord(kind);
        w.last_point = (k == len - 1);
        send_point(w, 0, 16'h0000);
      end
      rand_items += len;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain, then leave room for any stray word
    while (tour_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d lists from %0d points, %0d tour entries checked",
             lists_done, points_taken, visits_seen);
    $display("lists ranged from one point to past capacity, with a %0d cycle output hold-off",
             HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("nearest_neighbor_tour_order verification clean");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("nearest_neighbor_tour_order verification failed");
    end
    $finish;
  end

endmodule
